// File: rtl/piecewise_linear_curve_builder_defines.svh
`ifndef PIECEWISE_LINEAR_CURVE_BUILDER_DEFINES_SVH
`define PIECEWISE_LINEAR_CURVE_BUILDER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define PLCB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("plcb: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low
`define PLCB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("plcb: next-cycle check failed");

`endif

// File: rtl/plcb_pkg.sv
`default_nettype none

package plcb_pkg;

    // Default number of curves
    localparam int PLCB_CHANNELS = 3;

    // Curve geometry
    localparam int          LEVELS    = 256;
    localparam logic [7:0]  TOP_LEVEL = 8'hFF;

    // Operation codes
    localparam logic FUNC_KNOT   = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_OK             = 2'd0;
    localparam logic [1:0] ST_BAD_START      = 2'd1;
    localparam logic [1:0] ST_NOT_INCREASING = 2'd2;
    localparam logic [1:0] ST_BAD_END        = 2'd3;

endpackage

`default_nettype wire

// File: rtl/piecewise_linear_curve_builder.sv
// Lookup: decode, a registered table read, then the done strobe. Knot with nothing to fill:
// the done strobe comes from decode. Knot that fills a span of len entries: decode, then a
// bit-serial divide on the shared subtractor; then the same subtractor steps the interpolation
// one table entry per cycle, and a last knot at 255 also writes the top entry. One item at a time.
// The result is a one-cycle strobe and cannot be stalled. Reset clears the sequencer and the
// per-channel knot state; the curve table is not cleared and reads as written only.
`default_nettype none

`include "piecewise_linear_curve_builder_defines.svh"

module piecewise_linear_curve_builder #(
    parameter int CHANNELS = plcb_pkg::PLCB_CHANNELS
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic       func,
    input  wire logic [1:0] channel,
    input  wire logic [7:0] knot_pos,
    input  wire logic [7:0] knot_value,
    input  wire logic       knot_first,
    input  wire logic       knot_last,
    input  wire logic [7:0] lookup_index,
    output logic            done,
    output logic [7:0]      curve_value,
    output logic [1:0]      status
);
    import plcb_pkg::*;

    localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int DEPTH = CHANNELS * LEVELS;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_DIV,
        S_FILL,
        S_TOP,
        S_LOOK
    } state_t;

    state_t      state_reg;
    logic        func_reg;
    logic [1:0]  ch_reg;
    logic [7:0]  pos_reg;
    logic [7:0]  val_reg;
    logic        first_reg;
    logic        last_reg;
    logic [7:0]  idx_reg;

    logic [7:0]  prev_pos_reg   [CHANNELS];
    logic [7:0]  prev_val_reg   [CHANNELS];
    logic        active_reg     [CHANNELS];

    logic [7:0]  len_reg;
    logic [7:0]  v0_reg;
    logic        neg_reg;
    logic [7:0]  rem_reg;
    logic [7:0]  quo_reg;
    logic [2:0]  div_cnt_reg;
    logic [7:0]  r_acc_reg;
    logic [7:0]  q_acc_reg;
    logic [7:0]  fill_pos_reg;

    logic        done_reg;
    logic [7:0]  value_reg;
    logic [1:0]  status_reg;

    logic [7:0]  mem [DEPTH];
    logic [7:0]  rd_data_reg;

    logic            accept;
    logic            ch_ok;
    logic [CH_W-1:0] chi;
    logic [7:0]      p0;
    logic [7:0]      v0;
    logic [8:0]      step_sum;
    logic [8:0]      unit_a;
    logic [9:0]      unit_diff;
    logic            unit_ge;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic [7:0]      mem_wdata;
    logic [AW-1:0]   mem_raddr;

    assign accept = start && !busy;
    assign busy   = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign curve_value = value_reg;
    assign status      = status_reg;

    // Decode the latched channel
    assign ch_ok = ({1'b0, ch_reg} < 3'(CHANNELS));
    assign chi   = CH_W'(ch_reg);
    assign p0    = prev_pos_reg[chi];
    assign v0    = prev_val_reg[chi];

    // Shared subtract-and-compare unit: divide step or remainder step
    assign step_sum  = {1'b0, r_acc_reg} + {1'b0, rem_reg};
    assign unit_a    = (state_reg == S_DIV) ? {rem_reg, quo_reg[7]} : step_sum;
    assign unit_diff = {1'b0, unit_a} - {2'b00, len_reg};
    assign unit_ge   = ~unit_diff[9];

    // Table write port: interpolated span or the top entry
    assign mem_we    = (state_reg == S_FILL) || (state_reg == S_TOP);
    assign mem_waddr = (state_reg == S_TOP) ? AW'({ch_reg, TOP_LEVEL})
                                            : AW'({ch_reg, fill_pos_reg});
    assign mem_wdata = (state_reg == S_TOP) ? val_reg
                     : (neg_reg ? (v0_reg - q_acc_reg) : (v0_reg + q_acc_reg));
    assign mem_raddr = AW'({ch_reg, idx_reg});

    // Hold the curve table
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    // Sequence one item and hold the result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            done_reg     <= 1'b0;
            value_reg    <= '0;
            status_reg   <= ST_OK;
            func_reg     <= FUNC_KNOT;
            ch_reg       <= '0;
            pos_reg      <= '0;
            val_reg      <= '0;
            first_reg    <= 1'b0;
            last_reg     <= 1'b0;
            idx_reg      <= '0;
            len_reg      <= 8'd1;
            v0_reg       <= '0;
            neg_reg      <= 1'b0;
            rem_reg      <= '0;
            quo_reg      <= '0;
            div_cnt_reg  <= '0;
            r_acc_reg    <= '0;
            q_acc_reg    <= '0;
            fill_pos_reg <= '0;
            for (int c = 0; c < CHANNELS; c++)
            begin
                prev_pos_reg[c] <= '0;
                prev_val_reg[c] <= '0;
                active_reg[c]   <= 1'b0;
            end
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        func_reg  <= func;
                        ch_reg    <= channel;
                        pos_reg   <= knot_pos;
                        val_reg   <= knot_value;
                        first_reg <= knot_first;
                        last_reg  <= knot_last;
                        idx_reg   <= lookup_index;
                        state_reg <= S_DECODE;
                    end
                end
                S_DECODE:
                begin
                    value_reg  <= '0;
                    status_reg <= ST_OK;
                    if (!ch_ok)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else if (func_reg == FUNC_LOOKUP)
                    begin
                        state_reg <= S_LOOK;
                    end
                    else if (first_reg)
                    begin
                        // Start a curve, or flag a bad start or an early end
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                        if (pos_reg != 8'd0)
                        begin
                            active_reg[chi] <= 1'b0;
                            status_reg      <= ST_BAD_START;
                        end
                        else
                        begin
                            prev_pos_reg[chi] <= '0;
                            prev_val_reg[chi] <= val_reg;
                            active_reg[chi]   <= !last_reg;
                            status_reg        <= last_reg ? ST_BAD_END : ST_OK;
                        end
                    end
                    else if (!active_reg[chi])
                    begin
                        done_reg   <= 1'b1;
                        status_reg <= ST_BAD_START;
                        state_reg  <= S_IDLE;
                    end
                    else if (pos_reg <= p0)
                    begin
                        active_reg[chi] <= 1'b0;
                        done_reg        <= 1'b1;
                        status_reg      <= ST_NOT_INCREASING;
                        state_reg       <= S_IDLE;
                    end
                    else
                    begin
                        // Set up |dv| / len
                        len_reg      <= pos_reg - p0;
                        v0_reg       <= v0;
                        neg_reg      <= (val_reg < v0);
                        quo_reg      <= (val_reg < v0) ? (v0 - val_reg) : (val_reg - v0);
                        rem_reg      <= '0;
                        div_cnt_reg  <= '0;
                        r_acc_reg    <= '0;
                        q_acc_reg    <= '0;
                        fill_pos_reg <= p0;
                        state_reg    <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    // Advance one quotient bit
                    rem_reg     <= unit_ge ? unit_diff[7:0] : unit_a[7:0];
                    quo_reg     <= {quo_reg[6:0], unit_ge};
                    div_cnt_reg <= div_cnt_reg + 3'd1;
                    if (div_cnt_reg == 3'd7)
                    begin
                        state_reg <= S_FILL;
                    end
                end
                S_FILL:
                begin
                    // Advance the running quotient and remainder of |dv| * i / len
                    r_acc_reg    <= unit_ge ? unit_diff[7:0] : step_sum[7:0];
                    q_acc_reg    <= q_acc_reg + quo_reg + {7'd0, unit_ge};
                    fill_pos_reg <= fill_pos_reg + 8'd1;
                    if (fill_pos_reg == pos_reg - 8'd1)
                    begin
                        prev_pos_reg[chi] <= pos_reg;
                        prev_val_reg[chi] <= val_reg;
                        if (last_reg)
                        begin
                            active_reg[chi] <= 1'b0;
                        end
                        if (last_reg && (pos_reg == TOP_LEVEL))
                        begin
                            state_reg <= S_TOP;
                        end
                        else
                        begin
                            done_reg   <= 1'b1;
                            status_reg <= last_reg ? ST_BAD_END : ST_OK;
                            state_reg  <= S_IDLE;
                        end
                    end
                end
                S_TOP:
                begin
                    done_reg   <= 1'b1;
                    status_reg <= ST_OK;
                    state_reg  <= S_IDLE;
                end
                S_LOOK:
                begin
                    value_reg <= rd_data_reg;
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `PLCB_ASSERT_NEXT(a_accept_busy, accept, busy)
    `PLCB_ASSERT_NEXT(a_done_pulse, done, !done)
    `PLCB_ASSERT_NOW(a_lookup_ok, done && (func_reg == FUNC_LOOKUP), status == ST_OK)
    `PLCB_ASSERT_NOW(a_fill_below_knot, state_reg == S_FILL, fill_pos_reg < pos_reg)
    `PLCB_ASSERT_NOW(a_knot_load_zero, done && (func_reg == FUNC_KNOT), curve_value == 8'd0)

endmodule

`default_nettype wire
